>>> src/lzwc_pkg.sv
// Shared types and constants for the LZW compressor.
// No dependencies; imported by lzwc_dict and lzw_compressor_top.
package lzwc_pkg;

   localparam int CODE_BITS_DEFAULT = 12;
   localparam int CODE_FIELD_W      = 12;
   localparam int BYTE_W            = 8;
   localparam int FIRST_FREE        = 256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHASE,
      ST_NODE,
      ST_EMIT_MISS,
      ST_ADD,
      ST_ADD_LINK,
      ST_EMIT_LAST
   } lzwc_state_type;

   // dictionary write controls from the sequencer
   typedef struct packed {
      logic fc_we;
      logic node_we;
      logic root_set;
      logic root_clear;
   } lzwc_ctrl_type;

endpackage

>>> src/lzwc_dict.sv
// Dictionary storage: first-child link RAM, node RAM (pair + sibling link),
// and valid bits for the 256 single-byte roots. Depends on lzwc_pkg.
module lzwc_dict
   import lzwc_pkg::*;
#(
   parameter int CODE_BITS = CODE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lzwc_ctrl_type             ctrl,
   input  logic [CODE_BITS-1:0]      fc_raddr,
   input  logic [CODE_BITS-1:0]      fc_waddr,
   input  logic [CODE_BITS-1:0]      fc_wdata,
   input  logic [CODE_BITS-1:0]      node_raddr,
   input  logic [CODE_BITS-1:0]      node_waddr,
   input  logic [2*CODE_BITS+7:0]    node_wdata,
   output logic [CODE_BITS-1:0]      fc_head,
   output logic [2*CODE_BITS+7:0]    node_rdata
);

   localparam int DEPTH  = 1 << CODE_BITS;
   localparam int NODE_W = 2 * CODE_BITS + BYTE_W;

   logic [CODE_BITS-1:0] fc_mem [DEPTH];
   logic [NODE_W-1:0]    node_mem [DEPTH];

   logic [FIRST_FREE-1:0] root_valid_ff;
   logic [FIRST_FREE-1:0] root_valid_in;
   logic [CODE_BITS-1:0]  fc_rd_ff;
   logic                  head_zero_ff;
   logic [NODE_W-1:0]     node_rd_ff;
   logic                  rd_is_root;
   logic                  wr_is_root;

   assign rd_is_root = (fc_raddr[CODE_BITS-1:BYTE_W] == '0);
   assign wr_is_root = (fc_waddr[CODE_BITS-1:BYTE_W] == '0);

   always_comb begin
      root_valid_in = root_valid_ff;
      if (ctrl.root_clear) begin
         root_valid_in = '0;
      end else if (ctrl.root_set && wr_is_root) begin
         root_valid_in[fc_waddr[BYTE_W-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_valid_ff <= '0;
      end else begin
         root_valid_ff <= root_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.fc_we) begin
         fc_mem[fc_waddr] <= fc_wdata;
      end
      fc_rd_ff     <= fc_mem[fc_raddr];
      // a root with no children this stream reads as an empty list
      head_zero_ff <= rd_is_root && !root_valid_ff[fc_raddr[BYTE_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ctrl.node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      node_rd_ff <= node_mem[node_raddr];
   end

   assign fc_head    = head_zero_ff ? '0 : fc_rd_ff;
   assign node_rdata = node_rd_ff;

endmodule

>>> src/lzw_compressor_top.sv
// LZW compressor top level: byte in, dictionary codes out. Depends on lzwc_pkg, lzwc_dict.
// A stream's first byte just sets the prefix; each later byte reads the prefix's first-child
// link (CHASE) and walks its child list, one node RAM read per node (NODE). A miss emits the
// prefix code (EMIT_MISS) and, while the dictionary has free codes, adds a new code (ADD,
// ADD_LINK); EMIT_LAST emits the end-of-stream code. No new request while one is in work,
// and an emit step waits while the output register still holds an unaccepted code.
// Reset (synchronous, active high) clears control state and the root valid bits.
module lzw_compressor_top
   import lzwc_pkg::*;
#(
   parameter int CODE_BITS = CODE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] code, [15:12] zero
   output logic        rsp_tlast    // final_code
);

   localparam int KEY_W  = CODE_BITS + BYTE_W;
   localparam int NODE_W = KEY_W + CODE_BITS;

   lzwc_state_type state_ff, state_in;

   logic [CODE_BITS-1:0]    prefix_ff, prefix_in;
   logic                    prefix_valid_ff, prefix_valid_in;
   logic [CODE_BITS:0]      nf_ff, nf_in;
   logic [BYTE_W-1:0]       byte_ff, byte_in;
   logic                    last_ff, last_in;
   logic [CODE_BITS-1:0]    cur_ff, cur_in;
   logic [CODE_BITS-1:0]    head_ff, head_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CODE_FIELD_W-1:0] rsp_code_ff, rsp_code_in;
   logic                    rsp_final_ff, rsp_final_in;

   lzwc_ctrl_type           ctrl;
   logic [CODE_BITS-1:0]    fc_waddr, fc_wdata;
   logic [CODE_BITS-1:0]    node_raddr, node_waddr;
   logic [NODE_W-1:0]       node_wdata;
   logic [CODE_BITS-1:0]    fc_head;
   logic [NODE_W-1:0]       node_rdata;

   logic                    accept;
   logic                    out_free;
   logic                    out_load;
   logic                    dict_full;
   logic                    key_match;
   logic [CODE_BITS-1:0]    sibling;
   logic [CODE_BITS+CODE_FIELD_W-1:0] prefix_ext;

   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign dict_full  = nf_ff[CODE_BITS];
   // the shared compare: stored pair against the current (prefix, byte) key
   assign key_match  = (node_rdata[NODE_W-1:CODE_BITS] == {prefix_ff, byte_ff});
   assign sibling    = node_rdata[CODE_BITS-1:0];
   assign prefix_ext = {{CODE_FIELD_W{1'b0}}, prefix_ff};

   lzwc_dict #(
      .CODE_BITS (CODE_BITS)
   ) u_dict (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .fc_raddr   (prefix_ff),
      .fc_waddr   (fc_waddr),
      .fc_wdata   (fc_wdata),
      .node_raddr (node_raddr),
      .node_waddr (node_waddr),
      .node_wdata (node_wdata),
      .fc_head    (fc_head),
      .node_rdata (node_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (!prefix_valid_ff) begin
                  state_in = req_tlast ? ST_EMIT_LAST : ST_IDLE;
               end else begin
                  state_in = ST_CHASE;
               end
            end
         end
         ST_CHASE: begin
            state_in = (fc_head == '0) ? ST_EMIT_MISS : ST_NODE;
         end
         ST_NODE: begin
            if (key_match) begin
               state_in = last_ff ? ST_EMIT_LAST : ST_IDLE;
            end else if (sibling == '0) begin
               state_in = ST_EMIT_MISS;
            end
         end
         ST_EMIT_MISS: begin
            if (out_free) begin
               if (dict_full) begin
                  state_in = last_ff ? ST_EMIT_LAST : ST_IDLE;
               end else begin
                  state_in = ST_ADD;
               end
            end
         end
         ST_ADD: begin
            state_in = ST_ADD_LINK;
         end
         ST_ADD_LINK: begin
            state_in = last_ff ? ST_EMIT_LAST : ST_IDLE;
         end
         ST_EMIT_LAST: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      prefix_in       = prefix_ff;
      prefix_valid_in = prefix_valid_ff;
      nf_in           = nf_ff;
      byte_in         = byte_ff;
      last_in         = last_ff;
      cur_in          = cur_ff;
      head_in         = head_ff;
      rsp_code_in     = rsp_code_ff;
      rsp_final_in    = rsp_final_ff;
      out_load        = 1'b0;
      ctrl            = '0;
      fc_waddr        = prefix_ff;
      fc_wdata        = '0;
      node_raddr      = cur_ff;
      node_waddr      = nf_ff[CODE_BITS-1:0];
      node_wdata      = {prefix_ff, byte_ff, head_ff};
      req_tready      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               byte_in = req_tdata;
               last_in = req_tlast;
               if (!prefix_valid_ff) begin
                  prefix_in       = {{(CODE_BITS-BYTE_W){1'b0}}, req_tdata};
                  prefix_valid_in = 1'b1;
               end
            end
         end
         ST_CHASE: begin
            head_in    = fc_head;
            cur_in     = fc_head;
            node_raddr = fc_head;
         end
         ST_NODE: begin
            if (key_match) begin
               prefix_in = cur_ff;
            end else begin
               cur_in     = sibling;
               node_raddr = sibling;
            end
         end
         ST_EMIT_MISS: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_code_in  = prefix_ext[CODE_FIELD_W-1:0];
               rsp_final_in = 1'b0;
               if (dict_full) begin
                  prefix_in = {{(CODE_BITS-BYTE_W){1'b0}}, byte_ff};
               end
            end
         end
         ST_ADD: begin
            // new node goes to the head of its parent's child list
            ctrl.node_we  = 1'b1;
            ctrl.fc_we    = 1'b1;
            ctrl.root_set = 1'b1;
            fc_waddr      = prefix_ff;
            fc_wdata      = nf_ff[CODE_BITS-1:0];
         end
         ST_ADD_LINK: begin
            // new code starts with no children
            ctrl.fc_we = 1'b1;
            fc_waddr   = nf_ff[CODE_BITS-1:0];
            fc_wdata   = '0;
            nf_in      = nf_ff + 1'b1;
            prefix_in  = {{(CODE_BITS-BYTE_W){1'b0}}, byte_ff};
         end
         ST_EMIT_LAST: begin
            if (out_free) begin
               out_load        = 1'b1;
               rsp_code_in     = prefix_ext[CODE_FIELD_W-1:0];
               rsp_final_in    = 1'b1;
               prefix_in       = '0;
               prefix_valid_in = 1'b0;
               nf_in           = (CODE_BITS+1)'(FIRST_FREE);
               ctrl.root_clear = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         prefix_ff       <= '0;
         prefix_valid_ff <= 1'b0;
         nf_ff           <= (CODE_BITS+1)'(FIRST_FREE);
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         prefix_ff       <= prefix_in;
         prefix_valid_ff <= prefix_valid_in;
         nf_ff           <= nf_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      cur_ff       <= cur_in;
      head_ff      <= head_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16-CODE_FIELD_W){1'b0}}, rsp_code_ff};
   assign rsp_tlast  = rsp_final_ff;

`ifndef NO_ASSERTIONS
   // free code counter never runs past the code space
   a_nf_range: assert property (@(posedge clock) disable iff (reset)
      nf_ff <= (CODE_BITS+1)'(1 << CODE_BITS))
      else $error("next free code out of range");

   // with no prefix held the dictionary must be empty
   a_empty_dict: assert property (@(posedge clock) disable iff (reset)
      !prefix_valid_ff |-> nf_ff == (CODE_BITS+1)'(FIRST_FREE))
      else $error("dictionary not empty at stream start");

   // chain walk only visits stored codes
   a_node_code: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_NODE |-> cur_ff[CODE_BITS-1:BYTE_W] != '0)
      else $error("chain walk reached a single-byte code");

   // a request is never taken while a result is being produced
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> !out_load || $past(!prefix_valid_ff && req_tlast))
      else $error("result loaded right after an unrelated request");
`endif

endmodule
